@@ rtl/obb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box to aligned box package
// Default widths and the row-major layout of the 3x3 rotation matrix that the
// rotation and extent stages share.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int QUAT_WIDTH  = 16;

    localparam int MAT_DIM  = 3;
    localparam int MAT_SIZE = MAT_DIM * MAT_DIM;

    function automatic int unsigned mat_idx(input int unsigned row, input int unsigned col);
        return row * MAT_DIM + col;
    endfunction

endpackage

@@ rtl/obb_quat_rot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to rotation magnitudes
// Three stages: component products, rotation matrix entries, then rounded
// absolute values of the entries at the quaternion fraction scale.
// ----------------------------------------------------------------------------
module obb_quat_rot #(
    parameter  int QW = obb_pkg::QUAT_WIDTH,
    parameter  int SW = 1,
    localparam int AW = QW + 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [QW-1:0]        i_quat_w,
    input  logic signed [QW-1:0]        i_quat_x,
    input  logic signed [QW-1:0]        i_quat_y,
    input  logic signed [QW-1:0]        i_quat_z,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [8:0][AW-1:0]          o_amag,
    output logic [SW-1:0]               o_side
);

    localparam int PW = 2 * QW;
    localparam int RW = 2 * QW + 2;
    localparam int F  = QW - 2;

    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    localparam logic signed [RW-1:0] RONE  = RW'(1) <<< (2 * F);
    localparam logic [RW-1:0]        RHALF = RW'(1) << (F - 1);

    logic r_valid1, r_valid2, r_valid3;
    logic adv1, adv2, adv3;

    logic signed [PW-1:0] r_prod [9];
    logic signed [PW-1:0] n_prod [9];
    logic signed [RW-1:0] r_rmat [9];
    logic signed [RW-1:0] n_rmat [9];
    logic [8:0][AW-1:0]   r_amag;
    logic [8:0][AW-1:0]   n_amag;
    logic [SW-1:0]        r_side1, r_side2, r_side3;

    assign adv3    = !r_valid3 || i_ready;
    assign adv2    = !r_valid2 || adv3;
    assign adv1    = !r_valid1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        n_prod[P_XX] = PW'(i_quat_x) * PW'(i_quat_x);
        n_prod[P_YY] = PW'(i_quat_y) * PW'(i_quat_y);
        n_prod[P_ZZ] = PW'(i_quat_z) * PW'(i_quat_z);
        n_prod[P_XY] = PW'(i_quat_x) * PW'(i_quat_y);
        n_prod[P_XZ] = PW'(i_quat_x) * PW'(i_quat_z);
        n_prod[P_YZ] = PW'(i_quat_y) * PW'(i_quat_z);
        n_prod[P_WX] = PW'(i_quat_w) * PW'(i_quat_x);
        n_prod[P_WY] = PW'(i_quat_w) * PW'(i_quat_y);
        n_prod[P_WZ] = PW'(i_quat_w) * PW'(i_quat_z);
    end

    always_comb begin
        n_rmat[obb_pkg::mat_idx(0, 0)] =
            RONE - ((RW'(r_prod[P_YY]) + RW'(r_prod[P_ZZ])) <<< 1);
        n_rmat[obb_pkg::mat_idx(0, 1)] = (RW'(r_prod[P_XY]) - RW'(r_prod[P_WZ])) <<< 1;
        n_rmat[obb_pkg::mat_idx(0, 2)] = (RW'(r_prod[P_XZ]) + RW'(r_prod[P_WY])) <<< 1;
        n_rmat[obb_pkg::mat_idx(1, 0)] = (RW'(r_prod[P_XY]) + RW'(r_prod[P_WZ])) <<< 1;
        n_rmat[obb_pkg::mat_idx(1, 1)] =
            RONE - ((RW'(r_prod[P_XX]) + RW'(r_prod[P_ZZ])) <<< 1);
        n_rmat[obb_pkg::mat_idx(1, 2)] = (RW'(r_prod[P_YZ]) - RW'(r_prod[P_WX])) <<< 1;
        n_rmat[obb_pkg::mat_idx(2, 0)] = (RW'(r_prod[P_XZ]) - RW'(r_prod[P_WY])) <<< 1;
        n_rmat[obb_pkg::mat_idx(2, 1)] = (RW'(r_prod[P_YZ]) + RW'(r_prod[P_WX])) <<< 1;
        n_rmat[obb_pkg::mat_idx(2, 2)] =
            RONE - ((RW'(r_prod[P_XX]) + RW'(r_prod[P_YY])) <<< 1);
    end

    always_comb begin
        logic [RW-1:0] mag;
        logic [RW-1:0] rnd;
        for (int k = 0; k < 9; k++) begin
            mag       = r_rmat[k][RW-1] ? RW'(-r_rmat[k]) : RW'(r_rmat[k]);
            rnd       = mag + RHALF;
            n_amag[k] = rnd[RW-1:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_valid1 <= i_valid;
            end
            if (adv2) begin
                r_valid2 <= r_valid1;
            end
            if (adv3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_prod  <= n_prod;
            r_side1 <= i_side;
        end
        if (adv2) begin
            r_rmat  <= n_rmat;
            r_side2 <= r_side1;
        end
        if (adv3) begin
            r_amag  <= n_amag;
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_valid3;
    assign o_amag  = r_amag;
    assign o_side  = r_side3;

endmodule

@@ rtl/obb_extent.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned extent accumulator
// Two stages: the nine magnitude by edge products, then the row sums rounded
// back to coordinate scale.
// ----------------------------------------------------------------------------
module obb_extent #(
    parameter  int CW  = obb_pkg::COORD_WIDTH,
    parameter  int QW  = obb_pkg::QUAT_WIDTH,
    parameter  int SW  = 1,
    localparam int EW  = CW - 1,
    localparam int AW  = QW + 4,
    localparam int SZW = CW + 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [8:0][AW-1:0]  i_amag,
    input  logic [2:0][EW-1:0]  i_edge,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0][SZW-1:0] o_size,
    output logic [SW-1:0]       o_side
);

    localparam int PW   = AW + EW;
    localparam int SUMW = PW + 2;
    localparam int F    = QW - 2;

    localparam logic [SUMW-1:0] SHALF = SUMW'(1) << (F - 1);

    logic r_valid4, r_valid5;
    logic adv4, adv5;

    logic [8:0][PW-1:0]  r_prod;
    logic [8:0][PW-1:0]  n_prod;
    logic [2:0][SZW-1:0] r_size;
    logic [2:0][SZW-1:0] n_size;
    logic [SW-1:0]       r_side4, r_side5;

    assign adv5    = !r_valid5 || i_ready;
    assign adv4    = !r_valid4 || adv5;
    assign o_ready = adv4;

    for (genvar i = 0; i < 3; i++) begin : g_row
        logic [SUMW-1:0] row_sum;
        for (genvar j = 0; j < 3; j++) begin : g_col
            assign n_prod[obb_pkg::mat_idx(i, j)] =
                PW'(i_amag[obb_pkg::mat_idx(i, j)]) * PW'(i_edge[j]);
        end
        assign row_sum = SUMW'(r_prod[obb_pkg::mat_idx(i, 0)])
                       + SUMW'(r_prod[obb_pkg::mat_idx(i, 1)])
                       + SUMW'(r_prod[obb_pkg::mat_idx(i, 2)]) + SHALF;
        assign n_size[i] = row_sum[SUMW-1:F];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid4 <= 1'b0;
            r_valid5 <= 1'b0;
        end else begin
            if (adv4) begin
                r_valid4 <= i_valid;
            end
            if (adv5) begin
                r_valid5 <= r_valid4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_prod  <= n_prod;
            r_side4 <= i_side;
        end
        if (adv5) begin
            r_size  <= n_size;
            r_side5 <= r_side4;
        end
    end

    assign o_valid = r_valid5;
    assign o_size  = r_size;
    assign o_side  = r_side5;

endmodule

@@ rtl/obb_bound.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum corner and saturation
// Output stage: subtracts half the extent from the center and saturates the
// corner and the size to their output ranges.
// ----------------------------------------------------------------------------
module obb_bound #(
    parameter  int CW  = obb_pkg::COORD_WIDTH,
    localparam int EW  = CW - 1,
    localparam int SZW = CW + 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0][SZW-1:0] i_size,
    input  logic [2:0][CW-1:0]  i_pos,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0][CW-1:0]  o_min,
    output logic [2:0][EW-1:0]  o_size
);

    localparam int MW = SZW + 2;

    localparam logic signed [MW-1:0] CMAX = (MW'(1) <<< (CW - 1)) - MW'(1);
    localparam logic signed [MW-1:0] CMIN = -CMAX - MW'(1);

    logic adv6;
    logic r_valid6;

    logic [2:0][CW-1:0] r_min;
    logic [2:0][CW-1:0] n_min;
    logic [2:0][EW-1:0] r_size;
    logic [2:0][EW-1:0] n_size;

    assign adv6    = !r_valid6 || !i_stall;
    assign o_ready = adv6;

    always_comb begin
        logic [SZW:0]           up;
        logic [SZW-1:0]         half;
        logic signed [CW-1:0]   pos;
        logic signed [MW-1:0]   mn;
        for (int i = 0; i < 3; i++) begin
            up   = {1'b0, i_size[i]} + (SZW + 1)'(1);
            half = up[SZW:1];
            pos  = i_pos[i];
            mn   = MW'(pos) - $signed({2'b00, half});
            if (mn > CMAX) begin
                n_min[i] = CMAX[CW-1:0];
            end else if (mn < CMIN) begin
                n_min[i] = CMIN[CW-1:0];
            end else begin
                n_min[i] = mn[CW-1:0];
            end
            if (|i_size[i][SZW-1:EW]) begin
                n_size[i] = {EW{1'b1}};
            end else begin
                n_size[i] = i_size[i][EW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid6 <= 1'b0;
        end else if (adv6) begin
            r_valid6 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv6) begin
            r_min  <= n_min;
            r_size <= n_size;
        end
    end

    assign o_valid = r_valid6;
    assign o_min   = r_min;
    assign o_size  = r_size;

endmodule

@@ rtl/oriented_box_to_aabb_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box to axis-aligned box unit
// Converts a box given by center, quaternion and edge lengths into the
// minimum corner and size of the aligned box that encloses it.
// ----------------------------------------------------------------------------
// The unit takes one box per clock cycle while o_stall is low and returns
// its aligned box through a pipeline: three stages turn the quaternion into
// rounded rotation magnitudes, two multiply them by the edges and sum the
// rows, and one forms the minimum corner and saturates. Each stage holds its
// own valid bit, so a stall on the output fills empty stages first and
// reaches o_stall only when every stage holds a beat. The quaternion is
// taken as unit length, and results beyond range saturate.
module oriented_box_to_aabb_unit #(
    parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH,
    parameter int QUAT_WIDTH  = obb_pkg::QUAT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]  i_quat_z,
    input  logic [COORD_WIDTH-2:0]        i_edge_x,
    input  logic [COORD_WIDTH-2:0]        i_edge_y,
    input  logic [COORD_WIDTH-2:0]        i_edge_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_min_x,
    output logic signed [COORD_WIDTH-1:0] o_min_y,
    output logic signed [COORD_WIDTH-1:0] o_min_z,
    output logic [COORD_WIDTH-2:0]        o_size_x,
    output logic [COORD_WIDTH-2:0]        o_size_y,
    output logic [COORD_WIDTH-2:0]        o_size_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = COORD_WIDTH - 1;
    localparam int AW   = QUAT_WIDTH + 4;
    localparam int SZW  = COORD_WIDTH + 7;
    localparam int RSW  = 3 * CW + 3 * EW;
    localparam int PSW  = 3 * CW;

    logic                rot_ready;
    logic                rot_valid;
    logic [8:0][AW-1:0]  rot_amag;
    logic [RSW-1:0]      rot_side_in;
    logic [RSW-1:0]      rot_side_out;

    logic                ext_ready;
    logic                ext_valid;
    logic [2:0][EW-1:0]  ext_edge;
    logic [2:0][SZW-1:0] ext_size;
    logic [PSW-1:0]      ext_side;

    logic                bnd_ready;
    logic [2:0][CW-1:0]  bnd_pos;
    logic [2:0][CW-1:0]  bnd_min;
    logic [2:0][EW-1:0]  bnd_size;

    assign rot_side_in = {i_edge_z, i_edge_y, i_edge_x, i_pos_z, i_pos_y, i_pos_x};

    obb_quat_rot #(
        .QW (QUAT_WIDTH),
        .SW (RSW)
    ) u_quat_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (rot_ready),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_side   (rot_side_in),
        .o_valid  (rot_valid),
        .i_ready  (ext_ready),
        .o_amag   (rot_amag),
        .o_side   (rot_side_out)
    );

    assign ext_edge = rot_side_out[PSW +: 3 * EW];

    obb_extent #(
        .CW (COORD_WIDTH),
        .QW (QUAT_WIDTH),
        .SW (PSW)
    ) u_extent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rot_valid),
        .o_ready (ext_ready),
        .i_amag  (rot_amag),
        .i_edge  (ext_edge),
        .i_side  (rot_side_out[PSW-1:0]),
        .o_valid (ext_valid),
        .i_ready (bnd_ready),
        .o_size  (ext_size),
        .o_side  (ext_side)
    );

    assign bnd_pos = ext_side;

    obb_bound #(
        .CW (COORD_WIDTH)
    ) u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ext_valid),
        .o_ready (bnd_ready),
        .i_size  (ext_size),
        .i_pos   (bnd_pos),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_min   (bnd_min),
        .o_size  (bnd_size)
    );

    assign o_stall  = !rot_ready;
    assign o_min_x  = bnd_min[0];
    assign o_min_y  = bnd_min[1];
    assign o_min_z  = bnd_min[2];
    assign o_size_x = bnd_size[0];
    assign o_size_y = bnd_size[1];
    assign o_size_z = bnd_size[2];

    // An empty output stage lets every stage advance, so the input is free.
    a_idle_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output stage is empty");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output beat");

    a_ext_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ext_valid && !bnd_ready) |=> ext_valid)
        else $error("extent beat dropped while the output stage was full");

endmodule
